>>> rtl/core/fan_curve_with_down_lag_assert.svh
// ----------------------------------------------------------------------------
// fan_curve_with_down_lag_assert.svh
// assertion macros shared by the fan curve rtl
// ----------------------------------------------------------------------------
`ifndef FAN_CURVE_WITH_DOWN_LAG_ASSERT_SVH
`define FAN_CURVE_WITH_DOWN_LAG_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define FCDL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fan curve assertion failed");

// next-cycle implication, checked on every rising edge outside reset
`define FCDL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fan curve assertion failed");

`endif

>>> rtl/core/fcdl_pkg.sv
// ----------------------------------------------------------------------------
// fcdl_pkg
// types and constants of the fan curve with down lag
// ----------------------------------------------------------------------------
`default_nettype none

package fcdl_pkg;

  localparam int TEMP_W  = 8;
  localparam int DUTY_W  = 7;
  localparam int LAG_W   = 5;
  localparam int CFG_W   = 7;
  localparam int INDEX_W = 2;

  // curve: (12*t - 200) / 7, numerator held in 12 bits
  localparam int NUM_W       = 12;
  localparam int QUOT_W      = 9;
  localparam int RECIP_W     = 13;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int RECIP_SHIFT = 15;

  localparam logic [NUM_W-1:0]   CURVE_SUB   = NUM_W'(200);
  // ceil(2^15 / 7): exact quotient for numerators below 5461
  localparam logic [RECIP_W-1:0] CURVE_RECIP = RECIP_W'(4682);
  localparam logic [DUTY_W-1:0]  STEP_GUARD  = DUTY_W'(100);

  localparam logic [DUTY_W-1:0] MIN_DUTY_RST  = DUTY_W'(45);
  localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = DUTY_W'(100);
  localparam logic [DUTY_W-1:0] STEP_DOWN_RST = DUTY_W'(6);
  localparam logic [LAG_W-1:0]  LAG_RST       = LAG_W'(10);
  localparam logic [TEMP_W-1:0] LOWEST_RST    = '1;

  typedef enum logic [INDEX_W-1:0] {
    REG_MIN_DUTY,
    REG_MAX_DUTY,
    REG_STEP_DOWN,
    REG_LAG_SAMPLES
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/core/fan_curve_with_down_lag.sv
// ----------------------------------------------------------------------------
// fan_curve_with_down_lag
// fan duty from a temperature curve, with a lag on downward moves
//
// input stream: one temperature sample per transfer on s_axis_*
// output stream: one result per sample on m_axis_*, holding the current
//   duty, a recompute flag in tuser and the running min and max temperature
// output timing: the result of a sample shows on m_axis in the cycle after its
//   transfer, from a single output register
// throughput: one sample per cycle while m_axis_tready is high; the curve, clamp
//   and step limit are one short combinational pass feeding state and output register
// stalls: s_axis_tready stays high while the output register is empty or
//   being drained, so a new sample is taken in the cycle its predecessor
//   leaves; with m_axis_tready low the result holds and input is refused
// configuration: cfg_wr_en writes cfg_wdata to register cfg_addr at once,
//   to be used only while no sample is in flight
// reset: rst (synchronous) restores the register defaults, clears the duty
//   and lag, sets min to 255 and max to 0, and empties the output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "fan_curve_with_down_lag_assert.svh"

module fan_curve_with_down_lag
  import fcdl_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration write port
  input  wire logic                       cfg_wr_en,
  input  wire logic [INDEX_W-1:0]         cfg_addr,
  input  wire logic [CFG_W-1:0]           cfg_wdata,
  // sample input
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,  // temperature[7:0]
  // result output
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // fan_duty[6:0], min_temp[14:7],
                                                         // max_temp[22:15], zero[23]
  output logic                            m_axis_tuser   // duty_updated
);

  // configuration registers
  logic [DUTY_W-1:0] min_duty;
  logic [DUTY_W-1:0] max_duty;
  logic [DUTY_W-1:0] max_step_down;
  logic [LAG_W-1:0]  lag_samples;

  // controller state
  logic [TEMP_W-1:0] previous_temp;
  logic [DUTY_W-1:0] duty;
  logic              lag_running;
  logic [LAG_W-1:0]  lag_count;
  logic [TEMP_W-1:0] lowest_temp;
  logic [TEMP_W-1:0] highest_temp;

  logic [TEMP_W-1:0] lowest_temp_next;
  logic [TEMP_W-1:0] highest_temp_next;
  logic [DUTY_W-1:0] duty_next;
  logic              lag_running_next;
  logic [LAG_W-1:0]  lag_count_next;
  logic              updated_next;

  logic              in_xfer;
  logic [TEMP_W-1:0] temp;

  // curve datapath
  logic [NUM_W-1:0]  temp_x12;
  logic [NUM_W-1:0]  numer;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [QUOT_W-1:0] lo_clamped;
  logic [DUTY_W-1:0] curve_duty;
  logic [DUTY_W-1:0] step_duty;
  logic [LAG_W-1:0]  lag_count_inc;

  assign temp          = s_axis_tdata;
  // output register is free when empty or emptied this cycle
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // 12*t as two shifts; below the offset the quotient is clamped anyway,
  // so a negative numerator is taken as zero
  assign temp_x12 = {1'b0, temp, 3'b000} + {2'b00, temp, 2'b00};
  assign numer    = (temp_x12 > CURVE_SUB) ? (temp_x12 - CURVE_SUB) : '0;

  // divide by 7 through the reciprocal
  assign prod = PROD_W'(numer) * PROD_W'(CURVE_RECIP);
  assign quot = prod[RECIP_SHIFT +: QUOT_W];

  // raise to min first, then lower to max (crossed limits give max)
  assign lo_clamped = (quot < QUOT_W'(min_duty)) ? QUOT_W'(min_duty) : quot;
  assign curve_duty = (lo_clamped > QUOT_W'(max_duty)) ? max_duty
                                                       : lo_clamped[DUTY_W-1:0];

  // limit the fall from the current duty while it is a sane percentage
  always_comb begin
    step_duty = curve_duty;
    if ((duty > curve_duty) && ((duty - curve_duty) > max_step_down) &&
        (duty <= STEP_GUARD)) begin
      step_duty = duty - max_step_down;
    end
  end

  // temperature extremes, this sample included
  assign lowest_temp_next  = (temp < lowest_temp)  ? temp : lowest_temp;
  assign highest_temp_next = (temp > highest_temp) ? temp : highest_temp;

  assign lag_count_inc = lag_count + LAG_W'(1);

  // rise recomputes at once; otherwise start or advance the lag
  always_comb begin
    duty_next        = duty;
    lag_running_next = lag_running;
    lag_count_next   = lag_count;
    updated_next     = 1'b0;
    if (temp > previous_temp) begin
      duty_next        = step_duty;
      updated_next     = 1'b1;
      lag_running_next = 1'b0;
      lag_count_next   = '0;
    end else if (lag_running) begin
      lag_count_next = lag_count_inc;
      // a lag of zero behaves as one since the compare always passes
      if (lag_count_inc >= lag_samples) begin
        duty_next        = step_duty;
        updated_next     = 1'b1;
        lag_running_next = 1'b0;
        lag_count_next   = '0;
      end
    end else begin
      lag_running_next = 1'b1;
      lag_count_next   = '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_duty      <= MIN_DUTY_RST;
      max_duty      <= MAX_DUTY_RST;
      max_step_down <= STEP_DOWN_RST;
      lag_samples   <= LAG_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_MIN_DUTY:    min_duty      <= cfg_wdata;
        REG_MAX_DUTY:    max_duty      <= cfg_wdata;
        REG_STEP_DOWN:   max_step_down <= cfg_wdata;
        REG_LAG_SAMPLES: lag_samples   <= cfg_wdata[LAG_W-1:0];
        default: ;
      endcase
    end
  end

  // controller state, advanced once per input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_temp <= '0;
      duty          <= '0;
      lag_running   <= 1'b0;
      lag_count     <= '0;
      lowest_temp   <= LOWEST_RST;
      highest_temp  <= '0;
    end else if (in_xfer) begin
      previous_temp <= temp;
      duty          <= duty_next;
      lag_running   <= lag_running_next;
      lag_count     <= lag_count_next;
      lowest_temp   <= lowest_temp_next;
      highest_temp  <= highest_temp_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_axis_tdata <= {1'b0, highest_temp_next, lowest_temp_next, duty_next};
      m_axis_tuser <= updated_next;
    end
  end

  // a delivered result never shows min above max
  `FCDL_ASSERT_IMPL(a_min_le_max, m_axis_tvalid, m_axis_tdata[14:7] <= m_axis_tdata[22:15])
  // an idle lag keeps a cleared count
  `FCDL_ASSERT_IMPL(a_lag_idle_clear, !lag_running, lag_count == '0)
  // a recompute always ends the lag
  `FCDL_ASSERT_IMPL(a_update_ends_lag, m_axis_tvalid && m_axis_tuser, !lag_running)
  // a rising sample is flagged as recomputed in the next result
  `FCDL_ASSERT_NEXT(a_rise_updates, in_xfer && (temp > previous_temp),
                    m_axis_tvalid && m_axis_tuser)
  // every accepted sample produces a result
  `FCDL_ASSERT_NEXT(a_xfer_gives_result, in_xfer, m_axis_tvalid)

endmodule

`default_nettype wire
